@@ design/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg: shared types and constants of the ipv4 prefix table
// Field widths, table sizing, operation and status codes, command and entry
// records passed between the front end, the scan engine and the table ram.
// ----------------------------------------------------------------------------
package lpm_pkg;

    // table sizing
    localparam int TABLE_DEPTH    = 256;
    localparam int NEXT_HOP_WIDTH = 16;
    localparam int IDX_W          = $clog2(TABLE_DEPTH);
    localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);

    // fixed field widths of the channels
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int HOP_W    = 16;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 9;

    // longest legal prefix
    localparam int MAX_LEN = 32;

    // command queue between front end and scan engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } lpm_op_e;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_NO_ENTRY = 2'd1,
        STATUS_FULL     = 2'd2
    } lpm_status_e;

    // classified command as it sits in the queue
    typedef struct packed {
        lpm_op_e                   op;
        logic [ADDR_W-1:0]         addr;
        logic [LEN_W-1:0]          len;
        logic [NEXT_HOP_WIDTH-1:0] hop;
    } lpm_cmd_t;

    // one table slot
    typedef struct packed {
        logic [ADDR_W-1:0]         addr;
        logic [LEN_W-1:0]          len;
        logic [NEXT_HOP_WIDTH-1:0] hop;
    } lpm_entry_t;

    // scan engine status seen by the top level
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] used;
    } lpm_stat_t;

endpackage

@@ design/lpm_if.sv @@
// ----------------------------------------------------------------------------
// lpm_if: request and response channels of the ipv4 prefix table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// request channel: operation, key address, prefix length, next hop
interface lpm_req_if import lpm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] key_addr;
    logic [LEN_W-1:0]  prefix_len;
    logic [HOP_W-1:0]  next_hop_in;

    modport source (
        output valid, op, key_addr, prefix_len, next_hop_in,
        input  ready
    );
    modport sink (
        input  valid, op, key_addr, prefix_len, next_hop_in,
        output ready
    );
endinterface

// response channel: status, hit flag, next hop, entry count
interface lpm_rsp_if import lpm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [HOP_W-1:0]    next_hop_out;
    logic [TOTAL_W-1:0]  entry_total;

    modport source (
        output valid, status, hit, next_hop_out, entry_total,
        input  ready
    );
    modport sink (
        input  valid, status, hit, next_hop_out, entry_total,
        output ready
    );
endinterface

@@ design/lpm_ram.sv @@
// ----------------------------------------------------------------------------
// lpm_ram: generic single write port, single read port ram
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/lpm_front.sv @@
// ----------------------------------------------------------------------------
// lpm_front: request intake and command queue
// Takes request beats, decodes the operation, saturates the prefix length,
// sizes the next hop and holds the commands in a short queue for the engine.
// ----------------------------------------------------------------------------
module lpm_front import lpm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    lpm_req_if.sink  req,
    output lpm_cmd_t cmd,
    output logic     cmd_valid,
    input  logic     cmd_pop
);

    lpm_cmd_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    lpm_cmd_t          new_cmd;
    logic              push;

    // classify the incoming beat
    always_comb
    begin
        new_cmd.op   = lpm_op_e'(req.op);
        new_cmd.addr = req.key_addr;
        new_cmd.len  = (req.prefix_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : req.prefix_len;
        new_cmd.hop  = NEXT_HOP_WIDTH'(req.next_hop_in);
    end

    assign req.ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];

    // queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd_pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

@@ design/lpm_back.sv @@
// ----------------------------------------------------------------------------
// lpm_back: table scan engine and response register
// Walks the used slots of the table ram one per cycle, finds the exact match
// and the longest prefix match, applies insert or remove, and hands the
// response to an output register that decouples it from the response sink.
// ----------------------------------------------------------------------------
module lpm_back import lpm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  lpm_cmd_t   cmd,
    input  logic       cmd_valid,
    output logic       cmd_pop,
    lpm_rsp_if.source  rsp,
    output lpm_stat_t  stat
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_APPLY = 5'b00100,
        ST_MOVE  = 5'b01000,
        ST_EMIT  = 5'b10000
    } lpm_state_e;

    lpm_state_e                state_reg, state_next;
    logic [CNT_W-1:0]          used_reg, used_next;
    logic                      pend_reg, pend_next;
    logic                      out_valid_reg, out_valid_next;

    lpm_cmd_t                  cmd_reg, cmd_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    logic                      found_reg, found_next;
    logic [IDX_W-1:0]          found_idx_reg, found_idx_next;
    logic                      best_valid_reg, best_valid_next;
    logic [LEN_W-1:0]          best_len_reg, best_len_next;
    logic [NEXT_HOP_WIDTH-1:0] best_hop_reg, best_hop_next;
    lpm_status_e               res_status_reg, res_status_next;
    logic                      res_hit_reg, res_hit_next;
    logic [HOP_W-1:0]          res_hop_reg, res_hop_next;
    lpm_status_e               out_status_reg, out_status_next;
    logic                      out_hit_reg, out_hit_next;
    logic [HOP_W-1:0]          out_hop_reg, out_hop_next;
    logic [TOTAL_W-1:0]        out_total_reg, out_total_next;

    logic                      rd_en, wr_en;
    logic [IDX_W-1:0]          rd_addr, wr_addr;
    lpm_entry_t                rd_data, wr_data, new_entry;
    logic                      exact_hit, prefix_hit;

    // top len bits set
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] sh;
        sh = LEN_W'(ADDR_W) - len;
        if (len == '0)
        begin
            return '0;
        end
        return {ADDR_W{1'b1}} << sh;
    endfunction

    lpm_ram #(
        .WIDTH ($bits(lpm_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // compare the slot read last cycle against the key
    assign exact_hit  = (rd_data.addr == cmd_reg.addr) && (rd_data.len == cmd_reg.len);
    assign prefix_hit = ((rd_data.addr ^ cmd_reg.addr) & prefix_mask(rd_data.len)) == '0;

    assign new_entry = '{addr: cmd_reg.addr, len: cmd_reg.len, hop: cmd_reg.hop};

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        cmd_next        = cmd_reg;
        issue_next      = issue_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        best_valid_next = best_valid_reg;
        best_len_next   = best_len_reg;
        best_hop_next   = best_hop_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_hop_next    = res_hop_reg;
        out_status_next = out_status_reg;
        out_hit_next    = out_hit_reg;
        out_hop_next    = out_hop_reg;
        out_total_next  = out_total_reg;
        cmd_pop         = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = new_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    cmd_next        = cmd;
                    issue_next      = '0;
                    pend_next       = 1'b0;
                    found_next      = 1'b0;
                    best_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue the next slot read
                if (issue_reg < used_reg)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                // evaluate the slot that came back; first exact match and
                // strictly longer prefixes only, so the lowest slot wins ties
                if (pend_reg)
                begin
                    if (exact_hit && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = pend_idx_reg;
                    end
                    if (prefix_hit && (!best_valid_reg || rd_data.len > best_len_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_len_next   = rd_data.len;
                        best_hop_next   = rd_data.hop;
                    end
                end
                if (!pend_reg && !(issue_reg < used_reg))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                res_status_next = STATUS_DONE;
                res_hit_next    = 1'b0;
                res_hop_next    = '0;
                state_next      = ST_EMIT;
                unique case (cmd_reg.op)
                    OP_INSERT:
                    begin
                        if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = found_idx_reg;
                        end
                        else if (used_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = used_reg[IDX_W-1:0];
                            used_next = used_reg + 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            res_status_next = STATUS_NO_ENTRY;
                        end
                        else
                        begin
                            // fetch the last slot to fill the hole
                            rd_en      = 1'b1;
                            rd_addr    = IDX_W'(used_reg - 1'b1);
                            state_next = ST_MOVE;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        res_hit_next = best_valid_reg;
                        res_hop_next = best_valid_reg ? HOP_W'(best_hop_reg) : '0;
                    end
                    OP_NONE:
                    begin
                        res_status_next = STATUS_DONE;
                    end
                endcase
            end
            ST_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = found_idx_reg;
                wr_data    = rd_data;
                used_next  = used_reg - 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // load the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_hit_next    = res_hit_reg;
                    out_hop_next    = res_hop_reg;
                    out_total_next  = TOTAL_W'(used_reg);
                    state_next      = ST_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        best_valid_reg <= best_valid_next;
        best_len_reg   <= best_len_next;
        best_hop_reg   <= best_hop_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        res_hop_reg    <= res_hop_next;
        out_status_reg <= out_status_next;
        out_hit_reg    <= out_hit_next;
        out_hop_reg    <= out_hop_next;
        out_total_reg  <= out_total_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.hit          = out_hit_reg;
    assign rsp.next_hop_out = out_hop_reg;
    assign rsp.entry_total  = out_total_reg;

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.used = used_reg;

endmodule

@@ design/ipv4_longest_prefix_match_table.sv @@
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_table: ipv4 longest prefix match table
// Insert, remove and lookup over a table of prefixes with next hops.
//
//   channel  dir  beat fields
//   -------  ---  ------------------------------------------------
//   req      in   op, key_addr, prefix_len, next_hop_in
//   rsp      out  status, hit, next_hop_out, entry_total
//
// An operation's duration grows with the number of used slots, set by the
// single read port of the table ram, which walks one used slot per cycle;
// a remove that finds its entry also passes through a move step.
// Reset clears the entry count and control state; the table ram needs
// no clearing pass. A two-beat queue keeps taking requests, until full,
// while the engine works or a response waits in the output register.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match_table import lpm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    lpm_req_if.sink   req,
    lpm_rsp_if.source rsp
);

    lpm_cmd_t  cmd;
    logic      cmd_valid;
    logic      cmd_pop;
    lpm_stat_t stat;

    lpm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    lpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp),
        .stat      (stat)
    );

`ifndef NO_ASSERTIONS
    // engine takes a command only when idle and one is queued
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (cmd_valid && !stat.busy))
        else $error("command taken while engine busy or queue empty");

    // entry count stays within the table
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.used <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // entry count moves by one at a time
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(stat.used) |->
            (stat.used == $past(stat.used) + 1'b1) || (stat.used == $past(stat.used) - 1'b1))
        else $error("entry count jumped");

    // a hit is only reported with a done status
    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.hit) |-> (rsp.status == STATUS_DONE))
        else $error("hit with failure status");
`endif

endmodule
